>>> rtl/core/cmts_pkg.sv
// shared types and constants of the cube map texel select pipeline
package cmts_pkg;

  localparam int unsigned CompW = 16;
  localparam int unsigned SizeW = 15;
  localparam int unsigned TexW  = 14;
  localparam int unsigned SumW  = CompW + 1;
  localparam int unsigned NumW  = SumW + TexW;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [SizeW-1:0] FaceSizeReset = 15'd1024;
  localparam logic [SizeW-1:0] FaceSizeMax   = 15'd16384;
  localparam logic [AddrW-1:0] AddrFaceSize  = 3'd0;

  typedef enum logic [2:0] {
    FacePosX = 3'd0,
    FaceNegX = 3'd1,
    FacePosY = 3'd2,
    FaceNegY = 3'd3,
    FacePosZ = 3'd4,
    FaceNegZ = 3'd5
  } face_e;

  typedef struct packed {
    logic signed [CompW-1:0] dir_x;
    logic signed [CompW-1:0] dir_y;
    logic signed [CompW-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic [TexW-1:0] texel_u;
    logic [TexW-1:0] texel_v;
    logic [2:0]      face;
    logic            zero_direction;
  } out_t;

  // projected coordinates, offset by the major magnitude
  typedef struct packed {
    logic [SumW-1:0]  sum_u;
    logic [SumW-1:0]  sum_v;
    logic [CompW-1:0] mag;
    face_e            face;
    logic             zero;
  } proj_t;

  // state of both restoring dividers
  typedef struct packed {
    logic [NumW-1:0] rem_u;
    logic [NumW-1:0] rem_v;
    logic [TexW-1:0] quo_u;
    logic [TexW-1:0] quo_v;
    logic [SumW-1:0] den;
    face_e           face;
    logic            zero;
  } div_t;

endpackage

>>> rtl/core/cmts_face_sel.sv
// major axis face selection and projection stage
module cmts_face_sel (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  cmts_pkg::in_t   data_i,
  output logic            valid_o,
  input  logic            stall_i,
  output cmts_pkg::proj_t data_o
);
  import cmts_pkg::*;

  logic [SumW-1:0]  x_e, y_e, z_e;
  logic [SumW-1:0]  nx, ny, nz;
  logic [CompW-1:0] ax, ay, az;
  logic [SumW-1:0]  cu, cv;
  logic [SumW:0]    su, sv;
  proj_t            proj_d, proj_q;
  logic             valid_q;

  always_comb begin
    x_e = {data_i.dir_x[CompW-1], data_i.dir_x};
    y_e = {data_i.dir_y[CompW-1], data_i.dir_y};
    z_e = {data_i.dir_z[CompW-1], data_i.dir_z};
    nx  = SumW'(0) - x_e;
    ny  = SumW'(0) - y_e;
    nz  = SumW'(0) - z_e;
    // most negative value comes out exact as an unsigned magnitude
    ax  = x_e[SumW-1] ? nx[CompW-1:0] : x_e[CompW-1:0];
    ay  = y_e[SumW-1] ? ny[CompW-1:0] : y_e[CompW-1:0];
    az  = z_e[SumW-1] ? nz[CompW-1:0] : z_e[CompW-1:0];

    proj_d.zero = (ax == '0) && (ay == '0) && (az == '0);

    if (ay >= ax && ay >= az) begin
      proj_d.mag = ay;
      cu = x_e;
      if (!y_e[SumW-1]) begin
        proj_d.face = FacePosY;
        cv = z_e;
      end else begin
        proj_d.face = FaceNegY;
        cv = nz;
      end
    end else if (ax >= az) begin
      proj_d.mag = ax;
      cv = ny;
      if (!x_e[SumW-1]) begin
        proj_d.face = FacePosX;
        cu = nz;
      end else begin
        proj_d.face = FaceNegX;
        cu = z_e;
      end
    end else begin
      proj_d.mag = az;
      cv = ny;
      if (!z_e[SumW-1]) begin
        proj_d.face = FacePosZ;
        cu = x_e;
      end else begin
        proj_d.face = FaceNegZ;
        cu = nx;
      end
    end

    // c + m lies in 0 .. 2m
    su = {cu[SumW-1], cu} + {2'b00, proj_d.mag};
    sv = {cv[SumW-1], cv} + {2'b00, proj_d.mag};
    proj_d.sum_u = su[SumW-1:0];
    proj_d.sum_v = sv[SumW-1:0];
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      proj_q <= proj_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = proj_q;

endmodule

>>> rtl/core/cmts_scale.sv
// scaling multiply stage, sets up both dividers
module cmts_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  cmts_pkg::proj_t            data_i,
  input  logic [cmts_pkg::TexW-1:0]  scale_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output cmts_pkg::div_t             data_o
);
  import cmts_pkg::*;

  div_t div_d, div_q;
  logic valid_q;

  always_comb begin
    div_d.rem_u = {{TexW{1'b0}}, data_i.sum_u} * {{SumW{1'b0}}, scale_i};
    div_d.rem_v = {{TexW{1'b0}}, data_i.sum_v} * {{SumW{1'b0}}, scale_i};
    div_d.quo_u = '0;
    div_d.quo_v = '0;
    div_d.den   = {data_i.mag, 1'b0};
    div_d.face  = data_i.face;
    div_d.zero  = data_i.zero;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = div_q;

endmodule

>>> rtl/core/cmts_div_step.sv
// one quotient bit of the two restoring dividers
module cmts_div_step #(
  parameter int unsigned Bit = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  cmts_pkg::div_t data_i,
  output logic           valid_o,
  input  logic           stall_i,
  output cmts_pkg::div_t data_o
);
  import cmts_pkg::*;

  logic [NumW-1:0] dsh;
  div_t            div_d, div_q;
  logic            valid_q;

  always_comb begin
    dsh   = {{TexW{1'b0}}, data_i.den} << Bit;
    div_d = data_i;
    if (data_i.rem_u >= dsh) begin
      div_d.rem_u      = data_i.rem_u - dsh;
      div_d.quo_u[Bit] = 1'b1;
    end
    if (data_i.rem_v >= dsh) begin
      div_d.rem_v      = data_i.rem_v - dsh;
      div_d.quo_v[Bit] = 1'b1;
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = div_q;

endmodule

>>> rtl/core/cube_map_texel_select.sv
// cube map texel select: top level with register port and pipeline
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  in_data_i (dir_x, dir_y, dir_z)
//   out      output     out_valid_o / out_stall_i out_data_o (texel_u/v, face, zero)
//   apb      input      psel, penable, pready    paddr, pwdata, prdata (face_size)
//
// one transaction per cycle while the output is not stalled; the stages are one face select stage,
// one multiply stage and one stage per quotient bit of the 14 bit divider
// every stage has its own valid bit and holds only while full and stalled,
// so empty stages keep filling behind a stalled result
// reset empties the pipeline and sets face_size to 1024
module cube_map_texel_select (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cmts_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cmts_pkg::out_t               out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cmts_pkg::AddrW-1:0]   paddr,
  input  logic [cmts_pkg::DataW-1:0]   pwdata,
  output logic [cmts_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import cmts_pkg::*;

  logic [SizeW-1:0] face_size_q, face_size_d;
  logic [SizeW-1:0] size_eff, size_m1;
  logic [TexW-1:0]  scale;

  proj_t proj;
  logic  proj_valid, proj_stall;
  div_t  div_data  [TexW+1];
  logic  div_valid [TexW+1];
  logic  div_stall [TexW+1];
  div_t  last;

  // register port
  assign pready = 1'b1;
  assign prdata = {{(DataW-SizeW){1'b0}}, face_size_q};

  always_comb begin
    face_size_d = face_size_q;
    if (psel && penable && pwrite && paddr == AddrFaceSize) begin
      face_size_d = pwdata[SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_size_q <= FaceSizeReset;
    end else begin
      face_size_q <= face_size_d;
    end
  end

  // zero size acts as one, oversize saturates
  always_comb begin
    if (face_size_q == '0) begin
      size_eff = SizeW'(1);
    end else if (face_size_q > FaceSizeMax) begin
      size_eff = FaceSizeMax;
    end else begin
      size_eff = face_size_q;
    end
    size_m1 = size_eff - SizeW'(1);
    scale   = size_m1[TexW-1:0];
  end

  cmts_face_sel u_face_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (proj_valid),
    .stall_i (proj_stall),
    .data_o  (proj)
  );

  cmts_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (proj_valid),
    .stall_o (proj_stall),
    .data_i  (proj),
    .scale_i (scale),
    .valid_o (div_valid[0]),
    .stall_i (div_stall[0]),
    .data_o  (div_data[0])
  );

  for (genvar i = 0; i < TexW; i++) begin : g_div
    cmts_div_step #(
      .Bit (TexW - 1 - i)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[i]),
      .stall_o (div_stall[i]),
      .data_i  (div_data[i]),
      .valid_o (div_valid[i+1]),
      .stall_i (div_stall[i+1]),
      .data_o  (div_data[i+1])
    );
  end

  assign div_stall[TexW] = out_stall_i;
  assign last            = div_data[TexW];
  assign out_valid_o     = div_valid[TexW];

  // a zero vector divides by zero; its texels are forced here
  always_comb begin
    out_data_o.texel_u        = last.zero ? '0 : last.quo_u;
    out_data_o.texel_v        = last.zero ? '0 : last.quo_v;
    out_data_o.face           = last.face;
    out_data_o.zero_direction = last.zero;
  end

endmodule

>>> rtl/core/cmts_checker.sv
// port level checks of the cube map texel select, bound to the top level
module cmts_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input cmts_pkg::out_t               out_data_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [cmts_pkg::AddrW-1:0]   paddr,
  input logic [cmts_pkg::DataW-1:0]   pwdata,
  input logic [cmts_pkg::DataW-1:0]   prdata,
  input logic                         pready
);
  import cmts_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input back pressure only ever comes from a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without output stall");

  // zero vector gives +y face and texel origin
  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_direction |->
      out_data_o.texel_u == '0 && out_data_o.texel_v == '0 &&
      out_data_o.face == FacePosY)
    else $error("zero direction result not forced");

  // texels stay inside the face
  a_texel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prdata[SizeW-1:0] != '0 && prdata[SizeW-1:0] <= FaceSizeMax |->
      out_data_o.texel_u < prdata[SizeW-1:0] && out_data_o.texel_v < prdata[SizeW-1:0])
    else $error("texel outside face");

  // face size write reads back
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr == AddrFaceSize |=>
      prdata[SizeW-1:0] == $past(pwdata[SizeW-1:0]))
    else $error("face size write lost");

endmodule

bind cube_map_texel_select cmts_checker u_cmts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);

>>> verif/tb_cube_map_texel_select.sv
// testbench for cube_map_texel_select: face choice and texel indices checked against a predictor
`timescale 1ns / 100ps

module tb_cube_map_texel_select;
  import cmts_pkg::*;

  localparam int unsigned IdleLimit     = 5000;
  localparam int unsigned DrainCycles   = 24;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned PressureItems = 80;
  localparam int unsigned RandomPhases  = 6;
  localparam int unsigned PhaseItems    = 98;
  localparam int unsigned SweepItems    = 8;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [AddrW-1:0] paddr     = '0;
  logic [DataW-1:0] pwdata    = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  out_t             pending_texels[$];
  logic [SizeW-1:0] face_size_now = FaceSizeReset;
  logic [CompW-1:0] corner_values[6] = '{16'h8000, 16'h8001, 16'hffff, 16'h0000,
                                         16'h0001, 16'h7fff};
  int               fail_count      = 0;
  int               directions_sent = 0;
  int               results_checked = 0;
  int               settings_used   = 1;
  int               zero_hits       = 0;
  int               face_hits[8]    = '{default: 0};
  int               burst_left      = 0;
  int               idle_cycles     = 0;
  int               hold_request    = 0;
  int               hold_left       = 0;
  int               pattern_left    = 0;
  int               pattern_phase   = 0;
  stall_mode_e      stall_mode      = StallNone;

  always #5 clk_i = ~clk_i;

  cube_map_texel_select dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // exact integer face projection, mirroring the float maths without rounding error
  function automatic out_t map_direction(input in_t dir, input logic [SizeW-1:0] size_reg);
    longint x, y, z, ax, ay, az, cu, cv, m, size, scale;
    face_e  face;
    out_t   res;
    x  = longint'($signed(dir.dir_x));
    y  = longint'($signed(dir.dir_y));
    z  = longint'($signed(dir.dir_z));
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    size = size_reg;
    if (size == 0) size = 1;
    if (size > FaceSizeMax) size = FaceSizeMax;
    scale = size - 1;
    // y wins ties, then x, then z
    if (ay >= ax && ay >= az) begin
      m  = ay;
      cu = x;
      if (y >= 0) begin
        face = FacePosY;
        cv   = z;
      end else begin
        face = FaceNegY;
        cv   = -z;
      end
    end else if (ax >= az) begin
      m  = ax;
      cv = -y;
      if (x >= 0) begin
        face = FacePosX;
        cu   = -z;
      end else begin
        face = FaceNegX;
        cu   = z;
      end
    end else begin
      m  = az;
      cv = -y;
      if (z >= 0) begin
        face = FacePosZ;
        cu   = x;
      end else begin
        face = FaceNegZ;
        cu   = -x;
      end
    end
    res.face           = face;
    res.zero_direction = (m == 0);
    if (m == 0) begin
      res.texel_u = '0;
      res.texel_v = '0;
    end else begin
      res.texel_u = TexW'(((cu + m) * scale) / (2 * m));
      res.texel_v = TexW'(((cv + m) * scale) / (2 * m));
    end
    return res;
  endfunction

  function automatic in_t make_dir(input int x, input int y, input int z);
    in_t d;
    d.dir_x = CompW'(x);
    d.dir_y = CompW'(y);
    d.dir_z = CompW'(z);
    return d;
  endfunction

  function automatic in_t random_direction();
    in_t              d;
    logic [CompW-1:0] a;
    d.dir_x = CompW'($urandom);
    d.dir_y = CompW'($urandom);
    d.dir_z = CompW'($urandom);
    a       = CompW'($urandom);
    case ($urandom_range(0, 9))
      5: begin
        // equal magnitudes with random signs, sometimes one axis dropped
        d.dir_x = $urandom_range(0, 1) ? a : -a;
        d.dir_y = $urandom_range(0, 1) ? a : -a;
        d.dir_z = $urandom_range(0, 1) ? a : -a;
        case ($urandom_range(0, 3))
          1: d.dir_x = '0;
          2: d.dir_y = '0;
          3: d.dir_z = '0;
          default: ;
        endcase
      end
      6: begin
        d.dir_x = CompW'($urandom_range(0, 6) - 3);
        d.dir_y = CompW'($urandom_range(0, 6) - 3);
        d.dir_z = CompW'($urandom_range(0, 6) - 3);
      end
      7: begin
        d.dir_x = corner_values[$urandom_range(0, 5)];
        d.dir_y = corner_values[$urandom_range(0, 5)];
        d.dir_z = corner_values[$urandom_range(0, 5)];
      end
      8: begin
        // near ties, off by one
        d.dir_x = a;
        d.dir_y = a + CompW'($urandom_range(0, 2) - 1);
        d.dir_z = $urandom_range(0, 1) ? -a : a + CompW'($urandom_range(0, 2) - 1);
      end
      default: ;
    endcase
    return d;
  endfunction

  task automatic report_error(input string msg);
    fail_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic send_direction(input in_t dir);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= dir;
    do @(posedge clk_i); while (in_stall);
  endtask

  // drain the pipeline, then write face_size over the register port
  task automatic set_face_size(input logic [DataW-1:0] value);
    in_valid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrFaceSize;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    face_size_now = value[SizeW-1:0];
    settings_used++;
  endtask

  task automatic test_directed_faces();
    send_direction(make_dir(0, 0, 0));
    send_direction(make_dir(32767, 0, 0));
    send_direction(make_dir(-32768, 0, 0));
    send_direction(make_dir(0, 32767, 0));
    send_direction(make_dir(0, -32768, 0));
    send_direction(make_dir(0, 0, 32767));
    send_direction(make_dir(0, 0, -32768));
    send_direction(make_dir(1000, 1000, 1000));
    send_direction(make_dir(-1000, -1000, 1000));
    send_direction(make_dir(500, 0, 500));
    send_direction(make_dir(-500, 0, -500));
    send_direction(make_dir(-32768, -32768, -32768));
    send_direction(make_dir(32767, -32768, 32767));
    send_direction(make_dir(-32768, 32767, -32768));
    send_direction(make_dir(1, 0, 0));
    send_direction(make_dir(0, 0, -1));
    send_direction(make_dir(1, -1, 1));
    send_direction(make_dir(32767, 32767, -32767));
    send_direction(make_dir(-32767, 32767, 32767));
    send_direction(make_dir(100, 20, -30));
    send_direction(make_dir(-7, 3, 5));
  endtask

  // smallest, largest, zero and out of range sizes
  task automatic test_face_size_extremes();
    logic [DataW-1:0] sizes[6];
    sizes = '{32'd1, 32'd16384, 32'd0, 32'd32767, 32'd2, 32'd16383};
    foreach (sizes[i]) begin
      set_face_size(sizes[i]);
      send_direction(make_dir(-32768, -32768, -32768));
      send_direction(make_dir(32767, 32767, -32767));
      repeat (SweepItems) send_direction(random_direction());
    end
  endtask

  // receiver holds off while the sender keeps going, so the pipe backs up
  task automatic test_pressure();
    set_face_size(DataW'($urandom_range(1, 16384)));
    hold_request = HoldCycles;
    burst_left   = PressureItems;
    repeat (PressureItems) send_direction(random_direction());
  endtask

  task automatic test_random();
    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph == 0) set_face_size(DataW'($urandom_range(1, 64)));
      else set_face_size(DataW'($urandom_range(1, 16384)));
      repeat (PhaseItems) send_direction(random_direction());
    end
  endtask

  // receiver stall pattern, with an occasional long hold on request
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        stall_mode   = stall_mode_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 120);
      end
      pattern_left--;
      pattern_phase = (pattern_phase + 1) % 5;
      case (stall_mode)
        StallLight:    out_stall <= ($urandom_range(0, 3) == 0);
        StallHeavy:    out_stall <= ($urandom_range(0, 1) == 1);
        StallPeriodic: out_stall <= (pattern_phase < 2);
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  // result checking and expectation capture
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (pending_texels.size() == 0) begin
          report_error($sformatf("result with nothing expected: u %0d v %0d face %0d zero %0b",
                                 out_data.texel_u, out_data.texel_v, out_data.face,
                                 out_data.zero_direction));
        end else begin
          want = pending_texels.pop_front();
          results_checked++;
          face_hits[want.face]++;
          if (want.zero_direction) zero_hits++;
          if (out_data.texel_u !== want.texel_u)
            report_error($sformatf("texel_u got %0d expected %0d", out_data.texel_u,
                                   want.texel_u));
          if (out_data.texel_v !== want.texel_v)
            report_error($sformatf("texel_v got %0d expected %0d", out_data.texel_v,
                                   want.texel_v));
          if (out_data.face !== want.face)
            report_error($sformatf("face got %0d expected %0d", out_data.face, want.face));
          if (out_data.zero_direction !== want.zero_direction)
            report_error($sformatf("zero_direction got %0b expected %0b",
                                   out_data.zero_direction, want.zero_direction));
        end
      end
      if (in_valid && !in_stall) begin
        pending_texels.push_back(map_direction(in_data, face_size_now));
        directions_sent++;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout with %0d results outstanding", pending_texels.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_faces();
    test_face_size_extremes();
    test_pressure();
    test_random();
    in_valid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d directions over %0d face size settings, %0d results checked",
             directions_sent, settings_used, results_checked);
    $display("faces +x %0d -x %0d +y %0d -y %0d +z %0d -z %0d, zero vectors %0d",
             face_hits[0], face_hits[1], face_hits[2], face_hits[3], face_hits[4],
             face_hits[5], zero_hits);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> cube_map_texel_select.f
rtl/core/cmts_pkg.sv
rtl/core/cmts_face_sel.sv
rtl/core/cmts_scale.sv
rtl/core/cmts_div_step.sv
rtl/core/cube_map_texel_select.sv
rtl/core/cmts_checker.sv
verif/tb_cube_map_texel_select.sv
